// File: src/cbcn_pkg.sv
// Shared types, constants and controller codes for the cluster box center block.
package cbcn_pkg;

   localparam int COORD_BITS       = 24;
   localparam int DIST_BITS        = 24;
   localparam int IDX_OUT_BITS     = 8;
   localparam int SQ_BITS          = 2 * COORD_BITS;
   localparam int ROOT_STEPS       = SQ_BITS / 2;
   localparam int STEP_BITS        = $clog2(ROOT_STEPS);
   localparam int REM_BITS         = DIST_BITS + 2;
   localparam int MAX_CLUSTERS_DEF = 256;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic KIND_CLUSTER = 1'b0;
   localparam logic KIND_FRAME   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_SQUARE,
      ST_ROOT,
      ST_BEST,
      ST_OUT_CLUSTER,
      ST_OUT_FRAME
   } state_type;

   typedef struct packed {
      logic accept;
      logic center;
      logic sq_step;
      logic root_step;
      logic best;
      logic frame_done;
      logic sel_frame;
   } cmd_type;

   typedef struct packed {
      logic closes;
      logic fend;
      logic axis_last;
      logic root_last;
   } status_type;

endpackage

// File: src/cbcn_ctrl.sv
// Controller state machine: sequences fold, center, squares, root, best update and result beats.
module cbcn_ctrl
   import cbcn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.closes) state_in = ST_CENTER;
         end
         ST_CENTER: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (status.axis_last) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (status.root_last) state_in = ST_BEST;
         end
         ST_BEST: begin
            state_in = ST_OUT_CLUSTER;
         end
         ST_OUT_CLUSTER: begin
            if (rsp_ready) state_in = status.fend ? ST_OUT_FRAME : ST_IDLE;
         end
         ST_OUT_FRAME: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_CENTER: begin
            cmd.center = 1'b1;
         end
         ST_SQUARE: begin
            cmd.sq_step = 1'b1;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
         end
         ST_BEST: begin
            cmd.best = 1'b1;
         end
         ST_OUT_CLUSTER: begin
            rsp_valid = 1'b1;
         end
         ST_OUT_FRAME: begin
            rsp_valid      = 1'b1;
            cmd.sel_frame  = 1'b1;
            cmd.frame_done = rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: src/cbcn_datapath.sv
// Datapath: box fold, center, shared squarer, bit-serial square root and closest-center registers.
module cbcn_datapath
   import cbcn_pkg::*;
#(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_point_z,
   input  logic                          req_cluster_end,
   input  logic                          req_frame_end,
   output logic                          rsp_kind,
   output logic signed [COORD_BITS-1:0]  rsp_center_x,
   output logic signed [COORD_BITS-1:0]  rsp_center_y,
   output logic signed [COORD_BITS-1:0]  rsp_center_z,
   output logic        [DIST_BITS-1:0]   rsp_distance,
   output logic        [IDX_OUT_BITS-1:0] rsp_cluster_index,
   output logic                          rsp_last
);

   localparam int CNT_BITS = $clog2(MAX_CLUSTERS + 1);
   localparam logic [CNT_BITS-1:0] CNT_MAX  = CNT_BITS'(MAX_CLUSTERS);
   localparam logic [CNT_BITS-1:0] IDX_TOP  = CNT_BITS'(MAX_CLUSTERS - 1);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(ROOT_STEPS - 1);

   logic signed [COORD_BITS-1:0] point   [3];
   logic signed [COORD_BITS-1:0] min_ff  [3];
   logic signed [COORD_BITS-1:0] max_ff  [3];
   logic signed [COORD_BITS-1:0] center_ff [3];
   logic signed [COORD_BITS-1:0] best_c_ff [3];
   logic                         open_ff;
   logic                         fend_ff;
   logic [CNT_BITS-1:0]          cnt_ff;
   logic [CNT_BITS-1:0]          idx_ff;
   logic [CNT_BITS-1:0]          best_idx_ff;
   logic [1:0]                   axis_ff;
   logic [SQ_BITS-1:0]           acc_ff;
   logic [SQ_BITS-1:0]           sq_ff;
   logic [SQ_BITS-1:0]           n_ff;
   logic [SQ_BITS-1:0]           best_sq_ff;
   logic [REM_BITS-1:0]          rem_ff;
   logic [DIST_BITS-1:0]         root_ff;
   logic [DIST_BITS-1:0]         best_dist_ff;
   logic [STEP_BITS-1:0]         step_ff;

   logic signed [COORD_BITS-1:0] sel_c;
   logic [COORD_BITS-1:0]        mag;
   logic [SQ_BITS-1:0]           prod;
   logic [SQ_BITS-1:0]           acc_sum;
   logic [REM_BITS-1:0]          rem_next;
   logic [REM_BITS-1:0]          trial;
   logic signed [COORD_BITS:0]   half_sum [3];
   logic [CNT_BITS+IDX_OUT_BITS-1:0] idx_wide;

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   always_comb begin
      case (axis_ff)
         AXIS_X:  sel_c = center_ff[0];
         AXIS_Y:  sel_c = center_ff[1];
         default: sel_c = center_ff[2];
      endcase
   end

   assign mag      = sel_c[COORD_BITS-1] ? COORD_BITS'(~sel_c + 1'b1) : COORD_BITS'(sel_c);
   assign prod     = SQ_BITS'(mag) * SQ_BITS'(mag);
   assign acc_sum  = acc_ff + prod;
   assign rem_next = {rem_ff[REM_BITS-3:0], n_ff[SQ_BITS-1 -: 2]};
   assign trial    = {root_ff, 2'b01};

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         half_sum[a] = {min_ff[a][COORD_BITS-1], min_ff[a]}
                     + {max_ff[a][COORD_BITS-1], max_ff[a]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         cnt_ff       <= '0;
         best_sq_ff   <= '0;
         best_dist_ff <= '0;
         best_idx_ff  <= '0;
         for (int a = 0; a < 3; a++) begin
            best_c_ff[a] <= '0;
         end
      end else begin
         if (cmd.accept) begin
            open_ff <= !(req_cluster_end || req_frame_end);
         end
         if (cmd.best) begin
            if (cnt_ff == '0 || sq_ff < best_sq_ff) begin
               best_sq_ff   <= sq_ff;
               best_dist_ff <= root_ff;
               best_idx_ff  <= idx_ff;
               for (int a = 0; a < 3; a++) begin
                  best_c_ff[a] <= center_ff[a];
               end
            end
            if (cnt_ff < CNT_MAX) cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.frame_done) begin
            cnt_ff       <= '0;
            best_sq_ff   <= '0;
            best_dist_ff <= '0;
            best_idx_ff  <= '0;
            for (int a = 0; a < 3; a++) begin
               best_c_ff[a] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fend_ff <= req_frame_end;
         for (int a = 0; a < 3; a++) begin
            if (!open_ff || point[a] < min_ff[a]) min_ff[a] <= point[a];
            if (!open_ff || point[a] > max_ff[a]) max_ff[a] <= point[a];
         end
      end
      if (cmd.center) begin
         for (int a = 0; a < 3; a++) begin
            center_ff[a] <= half_sum[a][COORD_BITS:1];
         end
         idx_ff  <= (cnt_ff < CNT_MAX) ? cnt_ff : IDX_TOP;
         axis_ff <= AXIS_X;
         acc_ff  <= '0;
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end
      if (cmd.sq_step) begin
         axis_ff <= axis_ff + 1'b1;
         if (axis_ff == AXIS_Z) begin
            sq_ff <= acc_sum;
            n_ff  <= acc_sum;
         end else begin
            acc_ff <= acc_sum;
         end
      end
      if (cmd.root_step) begin
         n_ff    <= {n_ff[SQ_BITS-3:0], 2'b00};
         step_ff <= step_ff + 1'b1;
         if (rem_next >= trial) begin
            rem_ff  <= rem_next - trial;
            root_ff <= {root_ff[DIST_BITS-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_next;
            root_ff <= {root_ff[DIST_BITS-2:0], 1'b0};
         end
      end
   end

   assign status.closes    = req_cluster_end || req_frame_end;
   assign status.fend      = fend_ff;
   assign status.axis_last = (axis_ff == AXIS_Z);
   assign status.root_last = (step_ff == STEP_LAST);

   assign idx_wide = {{IDX_OUT_BITS{1'b0}}, (cmd.sel_frame ? best_idx_ff : idx_ff)};

   assign rsp_kind          = cmd.sel_frame ? KIND_FRAME : KIND_CLUSTER;
   assign rsp_center_x      = cmd.sel_frame ? best_c_ff[0] : center_ff[0];
   assign rsp_center_y      = cmd.sel_frame ? best_c_ff[1] : center_ff[1];
   assign rsp_center_z      = cmd.sel_frame ? best_c_ff[2] : center_ff[2];
   assign rsp_distance      = cmd.sel_frame ? best_dist_ff : root_ff;
   assign rsp_cluster_index = idx_wide[IDX_OUT_BITS-1:0];
   assign rsp_last          = cmd.sel_frame || !fend_ff;

endmodule

// File: src/cluster_box_center_nearest_top.sv
// Top level of the cluster box center block: controller plus datapath.
//
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_ready | point_x/y/z, cluster_end, frame_end
//   rsp     | out | rsp_valid/rsp_ready | kind, center_x/y/z, distance, cluster_index, last
//
// A point that does not close a cluster is taken at once; points may follow back to back.
// A closing point passes the center, square, root and best states before its first beat:
// the shared squarer takes each axis in turn, and then the bit-serial square root runs.
// Each result beat is held until rsp_ready is high; a frame end gives two beats.
// Reset is synchronous; no clearing pass is needed, the block is ready the cycle after.
// req_ready stays low from a closing point until its last beat is taken.
module cluster_box_center_nearest_top
   import cbcn_pkg::*;
#(
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [COORD_BITS-1:0]   req_point_x,
   input  logic signed [COORD_BITS-1:0]   req_point_y,
   input  logic signed [COORD_BITS-1:0]   req_point_z,
   input  logic                           req_cluster_end,
   input  logic                           req_frame_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_kind,
   output logic signed [COORD_BITS-1:0]   rsp_center_x,
   output logic signed [COORD_BITS-1:0]   rsp_center_y,
   output logic signed [COORD_BITS-1:0]   rsp_center_z,
   output logic        [DIST_BITS-1:0]    rsp_distance,
   output logic        [IDX_OUT_BITS-1:0] rsp_cluster_index,
   output logic                           rsp_last
);

   cmd_type    cmd;
   status_type status;

   cbcn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbcn_datapath #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_point_z       (req_point_z),
      .req_cluster_end   (req_cluster_end),
      .req_frame_end     (req_frame_end),
      .rsp_kind          (rsp_kind),
      .rsp_center_x      (rsp_center_x),
      .rsp_center_y      (rsp_center_y),
      .rsp_center_z      (rsp_center_z),
      .rsp_distance      (rsp_distance),
      .rsp_cluster_index (rsp_cluster_index),
      .rsp_last          (rsp_last)
   );

endmodule

// File: src/cbcn_checker.sv
// Port-level assertions for the cluster box center block, bound to the top level.
module cbcn_checker
   import cbcn_pkg::*;
(
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_kind,
   input logic signed [COORD_BITS-1:0]   rsp_center_x,
   input logic signed [COORD_BITS-1:0]   rsp_center_y,
   input logic signed [COORD_BITS-1:0]   rsp_center_z,
   input logic        [DIST_BITS-1:0]    rsp_distance,
   input logic        [IDX_OUT_BITS-1:0] rsp_cluster_index,
   input logic                           rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_center_x)
         && $stable(rsp_center_y) && $stable(rsp_center_z) && $stable(rsp_distance)
         && $stable(rsp_cluster_index) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("point taken while a result is pending");

   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FRAME |-> rsp_last)
      else $error("frame beat without last");

   a_frame_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_CLUSTER && !rsp_last
         |=> rsp_valid && rsp_kind == KIND_FRAME)
      else $error("frame beat does not follow the closing cluster beat");

endmodule

bind cluster_box_center_nearest_top cbcn_checker u_cbcn_checker (.*);
